>>> sv/i2cm_pkg.sv
// i2cm_pkg: shared types and codes of the i2c master bus engine
// no dependencies; imported by the core and the top level
package i2cm_pkg;

  localparam int TICKS_W = 16;

  // action codes
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_WRITE   = 3'd1;
  localparam logic [2:0] ACT_READ    = 3'd2;
  localparam logic [2:0] ACT_RECOVER = 3'd3;
  localparam logic [2:0] ACT_TXBYTE  = 3'd4;

  // completion status codes
  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_START_FAIL = 3'd1;
  localparam logic [2:0] STS_NO_ACK     = 3'd2;
  localparam logic [2:0] STS_RECOV_FAIL = 3'd3;
  localparam logic [2:0] STS_NOT_STUCK  = 3'd4;

  localparam logic [TICKS_W-1:0] PHASE_TICKS_RST = 16'd50;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] target_address;
    logic [7:0] byte_count;
    logic [7:0] tx_byte;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       want_byte;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       done_res;
    logic [2:0] status;
  } res_t;

endpackage

>>> sv/i2cm_ifs.sv
// i2cm_in_if / i2cm_out_if: valid/ready channels of the i2c master bus engine
// depends on nothing but plain logic vectors
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [6:0] target_address;
  logic [7:0] byte_count;
  logic [7:0] tx_byte;
  logic       sda_sample;

  modport source (output valid, action, target_address, byte_count, tx_byte, sda_sample,
                  input ready);
  modport sink (input valid, action, target_address, byte_count, tx_byte, sda_sample,
                output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       want_byte;
  logic [7:0] rx_data;
  logic       rx_valid;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, scl_level, sda_level, busy_res, want_byte, rx_data,
                  rx_valid, done_res, status, input ready);
  modport sink (input valid, scl_level, sda_level, busy_res, want_byte, rx_data,
                rx_valid, done_res, status, output ready);
endinterface

>>> sv/i2c_master_bus_engine_unit.sv
// channel   | dir | payload                                                 | handshake
// in_if     | in  | action, target_address, byte_count, tx_byte, sda_sample | valid/ready
// out_if    | out | scl/sda levels, busy, want_byte, rx byte, done, status  | valid/ready
// cfg_      | in  | phase_ticks (16 bit)                                    | cfg_we strobe
//
// one word per clock; a word passes an input register, then the step logic of
// i2cm_core writes the result register
// every word gives exactly one result word; the sequencer state moves as a word
// leaves the input register, so a stall on out_if holds both stages in place
// synchronous active-low reset: bus lines released, sequencer idle, phase_ticks 50
// depends on i2cm_pkg, i2cm_ifs and i2cm_core
module i2c_master_bus_engine_unit import i2cm_pkg::*; #(
  parameter int RECOVERY_PULSES = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [TICKS_W-1:0] cfg_wdata,
  i2cm_in_if.sink            in_if,
  i2cm_out_if.source         out_if
);

  logic [TICKS_W-1:0] phase_ticks_r;
  logic               in_v_r;
  item_t              in_word_r;
  logic               out_v_r;
  res_t               out_word_r;
  logic               advance;
  item_t              in_word;
  res_t               step_res;

  assign advance     = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !in_v_r || advance;

  always_comb begin
    in_word.action         = in_if.action;
    in_word.target_address = in_if.target_address;
    in_word.byte_count     = in_if.byte_count;
    in_word.tx_byte        = in_if.tx_byte;
    in_word.sda_sample     = in_if.sda_sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_we) begin
      phase_ticks_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_word_r <= in_word;
    end
  end

  i2cm_core #(
    .RECOVERY_PULSES (RECOVERY_PULSES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .itm         (in_word_r),
    .phase_ticks (phase_ticks_r),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= step_res;
    end
  end

  assign out_if.valid     = out_v_r;
  assign out_if.scl_level = out_word_r.scl_level;
  assign out_if.sda_level = out_word_r.sda_level;
  assign out_if.busy_res  = out_word_r.busy_res;
  assign out_if.want_byte = out_word_r.want_byte;
  assign out_if.rx_data   = out_word_r.rx_data;
  assign out_if.rx_valid  = out_word_r.rx_valid;
  assign out_if.done_res  = out_word_r.done_res;
  assign out_if.status    = out_word_r.status;

endmodule

>>> sv/i2cm_core.sv
// i2cm_core: bus sequencer state and the one-word step logic
// depends on i2cm_pkg
module i2cm_core import i2cm_pkg::*; #(
  parameter int RECOVERY_PULSES = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  item_t              itm,
  input  logic [TICKS_W-1:0] phase_ticks,
  output res_t               res
);

  localparam int RPW = $clog2(RECOVERY_PULSES + 1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_PRESTOP  = 4'd1;
  localparam logic [3:0] ST_START    = 4'd2;
  localparam logic [3:0] ST_TXBIT    = 4'd3;
  localparam logic [3:0] ST_ACKCHK   = 4'd4;
  localparam logic [3:0] ST_WAITBYTE = 4'd5;
  localparam logic [3:0] ST_RXBIT    = 4'd6;
  localparam logic [3:0] ST_RACK     = 4'd7;
  localparam logic [3:0] ST_FINSTOP  = 4'd8;
  localparam logic [3:0] ST_RECOV    = 4'd9;

  logic [3:0]         seq_r, seq_nxt;
  logic [1:0]         sub_r, sub_nxt;
  logic [TICKS_W-1:0] pcnt_r, pcnt_nxt;
  logic [7:0]         shreg_r, shreg_nxt;
  logic [3:0]         bitc_r, bitc_nxt;
  logic [7:0]         bytes_r, bytes_nxt;
  logic               is_read_r, is_read_nxt;
  logic [RPW-1:0]     rpl_r, rpl_nxt;
  logic [2:0]         pend_r, pend_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;

  logic               ent_go;
  logic [3:0]         ent_st;
  logic [1:0]         ent_sub;
  logic               done;
  logic [2:0]         sts;
  logic               rxv;
  logic [7:0]         rxd;
  logic               tick;
  logic [TICKS_W-1:0] len;
  logic [TICKS_W-1:0] pcnt_inc;
  logic               ph_end;
  logic [3:0]         bitc_inc;
  logic [RPW-1:0]     rpl_dec;

  assign len      = (phase_ticks == '0) ? TICKS_W'(1) : phase_ticks;
  assign pcnt_inc = (pcnt_r == '1) ? pcnt_r : pcnt_r + TICKS_W'(1);
  assign tick     = step && (seq_r != ST_IDLE) && (seq_r != ST_WAITBYTE);
  assign ph_end   = pcnt_inc >= len;
  assign bitc_inc = bitc_r + 4'd1;
  assign rpl_dec  = rpl_r - RPW'(1);

  always_comb begin
    seq_nxt     = seq_r;
    sub_nxt     = sub_r;
    pcnt_nxt    = pcnt_r;
    shreg_nxt   = shreg_r;
    bitc_nxt    = bitc_r;
    bytes_nxt   = bytes_r;
    is_read_nxt = is_read_r;
    rpl_nxt     = rpl_r;
    pend_nxt    = pend_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    ent_go      = 1'b0;
    ent_st      = seq_r;
    ent_sub     = sub_r;
    done        = 1'b0;
    sts         = STS_OK;
    rxv         = 1'b0;
    rxd         = '0;

    if (step && seq_r == ST_IDLE && (itm.action inside {ACT_WRITE, ACT_READ})) begin
      is_read_nxt = (itm.action == ACT_READ);
      bytes_nxt   = itm.byte_count;
      shreg_nxt   = {itm.target_address, itm.action == ACT_READ};
      bitc_nxt    = '0;
      pend_nxt    = STS_OK;
      ent_go      = 1'b1;
      ent_st      = ST_PRESTOP;
      ent_sub     = 2'd0;
    end else if (step && seq_r == ST_IDLE && itm.action == ACT_RECOVER) begin
      if (itm.sda_sample) begin
        done = 1'b1;
        sts  = STS_NOT_STUCK;
      end else begin
        rpl_nxt = RPW'(RECOVERY_PULSES);
        ent_go  = 1'b1;
        ent_st  = ST_RECOV;
        ent_sub = 2'd0;
      end
    end else if (step && seq_r == ST_WAITBYTE) begin
      if (itm.action == ACT_TXBYTE) begin
        shreg_nxt = itm.tx_byte;
        bytes_nxt = bytes_r - 8'd1;
        bitc_nxt  = '0;
        ent_go    = 1'b1;
        ent_st    = ST_TXBIT;
        ent_sub   = 2'd0;
      end
    end else if (tick) begin
      pcnt_nxt = pcnt_inc;
      if (ph_end) begin
        case (seq_r)
          ST_PRESTOP: begin
            ent_go = 1'b1;
            if (sub_r < 2'd3) begin
              ent_sub = sub_r + 2'd1;
            end else begin
              ent_st  = ST_START;
              ent_sub = 2'd0;
            end
          end
          ST_START: begin
            // sda must be high before the start edge and low after it
            if ((sub_r == 2'd0 && !itm.sda_sample) || (sub_r == 2'd1 && itm.sda_sample)) begin
              scl_nxt = 1'b1;
              sda_nxt = 1'b1;
              done    = 1'b1;
              sts     = STS_START_FAIL;
            end else if (sub_r < 2'd2) begin
              ent_go  = 1'b1;
              ent_sub = sub_r + 2'd1;
            end else begin
              bitc_nxt = '0;
              ent_go   = 1'b1;
              ent_st   = ST_TXBIT;
              ent_sub  = 2'd0;
            end
          end
          ST_TXBIT: begin
            ent_go = 1'b1;
            if (sub_r < 2'd2) begin
              ent_sub = sub_r + 2'd1;
            end else begin
              shreg_nxt = {shreg_r[6:0], 1'b0};
              ent_sub   = 2'd0;
              if (bitc_inc >= 4'd8) begin
                bitc_nxt = '0;
                ent_st   = ST_ACKCHK;
              end else begin
                bitc_nxt = bitc_inc;
              end
            end
          end
          ST_ACKCHK: begin
            ent_go = 1'b1;
            if (sub_r < 2'd2) begin
              ent_sub = sub_r + 2'd1;
            end else begin
              scl_nxt = 1'b0;
              ent_sub = 2'd0;
              if (itm.sda_sample) begin
                pend_nxt = STS_NO_ACK;
                ent_st   = ST_FINSTOP;
              end else if (bytes_r == '0) begin
                pend_nxt = STS_OK;
                ent_st   = ST_FINSTOP;
              end else if (is_read_r) begin
                shreg_nxt = '0;
                bitc_nxt  = '0;
                ent_st    = ST_RXBIT;
              end else begin
                ent_st = ST_WAITBYTE;
              end
            end
          end
          ST_RXBIT: begin
            ent_go = 1'b1;
            if (sub_r < 2'd2) begin
              ent_sub = sub_r + 2'd1;
            end else begin
              shreg_nxt = {shreg_r[6:0], itm.sda_sample};
              ent_sub   = 2'd0;
              if (bitc_inc >= 4'd8) begin
                bitc_nxt  = '0;
                bytes_nxt = bytes_r - 8'd1;
                ent_st    = ST_RACK;
              end else begin
                bitc_nxt = bitc_inc;
              end
            end
          end
          ST_RACK: begin
            ent_go = 1'b1;
            if (sub_r < 2'd3) begin
              ent_sub = sub_r + 2'd1;
            end else begin
              sda_nxt = 1'b1;
              rxv     = 1'b1;
              rxd     = shreg_r;
              ent_sub = 2'd0;
              if (bytes_r == '0) begin
                pend_nxt = STS_OK;
                ent_st   = ST_FINSTOP;
              end else begin
                shreg_nxt = '0;
                bitc_nxt  = '0;
                ent_st    = ST_RXBIT;
              end
            end
          end
          ST_FINSTOP: begin
            if (sub_r < 2'd3) begin
              ent_go  = 1'b1;
              ent_sub = sub_r + 2'd1;
            end else begin
              done = 1'b1;
              sts  = pend_r;
            end
          end
          ST_RECOV: begin
            if (sub_r == 2'd0) begin
              ent_go  = 1'b1;
              ent_sub = 2'd1;
            end else if (itm.sda_sample) begin
              // bus released, close with a stop
              pend_nxt = STS_OK;
              ent_go   = 1'b1;
              ent_st   = ST_FINSTOP;
              ent_sub  = 2'd0;
            end else begin
              rpl_nxt = rpl_dec;
              if (rpl_dec == '0) begin
                done = 1'b1;
                sts  = STS_RECOV_FAIL;
              end else begin
                ent_go  = 1'b1;
                ent_sub = 2'd0;
              end
            end
          end
          default: begin
            seq_nxt = ST_IDLE;
          end
        endcase
      end
    end

    if (done) begin
      seq_nxt  = ST_IDLE;
      sub_nxt  = 2'd0;
      pcnt_nxt = '0;
    end

    // line levels set on entry to a phase
    if (ent_go) begin
      seq_nxt  = ent_st;
      sub_nxt  = ent_sub;
      pcnt_nxt = '0;
      case (ent_st)
        ST_PRESTOP, ST_FINSTOP: begin
          case (ent_sub)
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = 1'b0;
            2'd2:    scl_nxt = 1'b1;
            default: sda_nxt = 1'b1;
          endcase
        end
        ST_START: begin
          case (ent_sub)
            2'd0: begin
              scl_nxt = 1'b1;
              sda_nxt = 1'b1;
            end
            2'd1:    sda_nxt = 1'b0;
            default: scl_nxt = 1'b0;
          endcase
        end
        ST_TXBIT: begin
          case (ent_sub)
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = shreg_nxt[7];
            default: scl_nxt = 1'b1;
          endcase
        end
        ST_ACKCHK: begin
          case (ent_sub)
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = 1'b1;
            default: scl_nxt = 1'b1;
          endcase
        end
        ST_RXBIT: begin
          if (ent_sub == 2'd0) begin
            scl_nxt = 1'b0;
          end else if (ent_sub == 2'd2) begin
            scl_nxt = 1'b1;
          end
        end
        ST_RACK: begin
          case (ent_sub)
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = (bytes_nxt == '0); // nack on the last byte
            2'd2:    scl_nxt = 1'b1;
            default: scl_nxt = 1'b0;
          endcase
        end
        ST_RECOV: begin
          scl_nxt = (ent_sub != 2'd0);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= ST_IDLE;
      sub_r     <= '0;
      pcnt_r    <= '0;
      shreg_r   <= '0;
      bitc_r    <= '0;
      bytes_r   <= '0;
      is_read_r <= 1'b0;
      rpl_r     <= '0;
      pend_r    <= STS_OK;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
    end else if (step) begin
      seq_r     <= seq_nxt;
      sub_r     <= sub_nxt;
      pcnt_r    <= pcnt_nxt;
      shreg_r   <= shreg_nxt;
      bitc_r    <= bitc_nxt;
      bytes_r   <= bytes_nxt;
      is_read_r <= is_read_nxt;
      rpl_r     <= rpl_nxt;
      pend_r    <= pend_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
    end
  end

  always_comb begin
    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.busy_res  = (seq_nxt != ST_IDLE);
    res.want_byte = (seq_nxt == ST_WAITBYTE);
    res.rx_data   = rxd;
    res.rx_valid  = rxv;
    res.done_res  = done;
    res.status    = sts;
  end

  // a finished transaction always leaves the sequencer idle
  assert property (@(posedge clk) disable iff (!rst_n)
    step && done |-> seq_nxt == ST_IDLE)
    else $error("done reported while sequencer stays busy");

  // a received byte is always followed by sda released
  assert property (@(posedge clk) disable iff (!rst_n)
    step && rxv |-> sda_nxt)
    else $error("sda held low after byte receive");

  // phase counting is frozen while a transmit byte is awaited
  assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == ST_WAITBYTE && !(step && itm.action == ACT_TXBYTE) |=> $stable(pcnt_r))
    else $error("phase counter moved while waiting for a byte");

  // bit counter wraps before reaching a full byte
  assert property (@(posedge clk) disable iff (!rst_n)
    bitc_r < 4'd8)
    else $error("bit counter out of range");

endmodule
